// ===== sv/ilp_pkg.sv =====
// Package for the integer literal parser: request types and shared constants.
// Used by every module of the block; depends on nothing else.
package ilp_pkg;

  localparam int unsigned VALUE_W = 63;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } ilp_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               parse_error;
  } ilp_out_t;

  // Largest accumulator that can still take one more decimal digit, and the
  // largest digit allowed when the accumulator sits exactly at that limit.
  localparam logic [VALUE_W-1:0] DEC_LIMIT      = 63'd922337203685477580;
  localparam logic [3:0]         DEC_LAST_DIGIT = 4'd7;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_F_LO  = 8'h66;
  localparam logic [7:0] CH_A_UP  = 8'h41;
  localparam logic [7:0] CH_F_UP  = 8'h46;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

endpackage

// ===== sv/ilp_in_reg.sv =====
// Input register of the integer literal parser.
// Holds one accepted character request until the parse stage consumes it; uses ilp_pkg.
module ilp_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  ilp_pkg::ilp_in_t in_item,
  output logic             in_ready,
  input  logic             consume,
  output logic             held_valid,
  output ilp_pkg::ilp_in_t held_item
);
  import ilp_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  ilp_in_t  item_r;

  // The register frees up in the same cycle that its content is consumed.
  assign in_ready  = !valid_r || consume;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !consume);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

// ===== sv/ilp_accum.sv =====
// Parse stage of the integer literal parser: prefix detection, digit decode,
// overflow check and the per-literal state registers. Uses ilp_pkg.
module ilp_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ilp_pkg::ilp_in_t  item,
  output ilp_pkg::ilp_out_t result
);
  import ilp_pkg::*;

  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               hex_r, hex_nxt;
  logic [1:0]         pos_r, pos_nxt;
  logic               fz_r, fz_nxt;
  logic               err_r, err_nxt;

  logic               is_dec, is_hex_lo, is_hex_up, bad_digit, overflow, prefix;
  logic [3:0]         digit;
  logic [VALUE_W-1:0] acc_x16, acc_x10, acc_upd, digit_ext;
  logic               take_digit;
  logic               err_upd;

  always_comb begin
    is_dec    = (item.char_code >= CH_ZERO) && (item.char_code <= CH_NINE);
    is_hex_lo = hex_r && (item.char_code >= CH_A_LO) && (item.char_code <= CH_F_LO);
    is_hex_up = hex_r && (item.char_code >= CH_A_UP) && (item.char_code <= CH_F_UP);
    bad_digit = !(is_dec || is_hex_lo || is_hex_up);

    if (is_hex_lo) begin
      digit = 4'(item.char_code - CH_A_LO + 8'd10);
    end else if (is_hex_up) begin
      digit = 4'(item.char_code - CH_A_UP + 8'd10);
    end else begin
      digit = 4'(item.char_code - CH_ZERO);
    end
    digit_ext = {{(VALUE_W-4){1'b0}}, digit};

    // A hex digit never overflows unless the top four bits are in use.
    if (hex_r) begin
      overflow = (acc_r[VALUE_W-1:VALUE_W-4] != 4'd0);
    end else begin
      overflow = (acc_r > DEC_LIMIT) || ((acc_r == DEC_LIMIT) && (digit > DEC_LAST_DIGIT));
    end

    acc_x16 = {acc_r[VALUE_W-5:0], 4'b0000} | digit_ext;
    acc_x10 = {acc_r[VALUE_W-4:0], 3'b000} + {acc_r[VALUE_W-2:0], 1'b0} + digit_ext;

    prefix = !err_r && (pos_r == POS_SECOND) && fz_r && !item.is_last &&
             ((item.char_code == CH_X_LO) || (item.char_code == CH_X_UP));

    take_digit = !err_r && !prefix && !bad_digit && !overflow;
    acc_upd    = take_digit ? (hex_r ? acc_x16 : acc_x10) : acc_r;
    err_upd    = err_r || (!prefix && (bad_digit || overflow));
  end

  always_comb begin
    acc_nxt = acc_r;
    hex_nxt = hex_r;
    pos_nxt = pos_r;
    fz_nxt  = fz_r;
    err_nxt = err_r;
    if (step) begin
      if (item.is_last) begin
        acc_nxt = '0;
        hex_nxt = 1'b0;
        pos_nxt = POS_FIRST;
        fz_nxt  = 1'b0;
        err_nxt = 1'b0;
      end else begin
        acc_nxt = acc_upd;
        hex_nxt = hex_r || prefix;
        pos_nxt = (pos_r == POS_LATER) ? POS_LATER : pos_r + 2'd1;
        fz_nxt  = fz_r || (!err_r && (pos_r == POS_FIRST) && (item.char_code == CH_ZERO));
        err_nxt = err_upd;
      end
    end
  end

  assign result.value       = err_upd ? '0 : acc_upd;
  assign result.parse_error = err_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      hex_r <= 1'b0;
      pos_r <= POS_FIRST;
      fz_r  <= 1'b0;
      err_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      hex_r <= hex_nxt;
      pos_r <= pos_nxt;
      fz_r  <= fz_nxt;
      err_r <= err_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.is_last |=> (pos_r == POS_FIRST) && !err_r && !hex_r && (acc_r == '0))
    else $error("parse state not cleared after last character");

  a_hex_needs_zero: assert property (@(posedge clk) disable iff (!rst_n)
    hex_r |-> fz_r && (pos_r == POS_LATER))
    else $error("hex mode without leading zero prefix");

  a_fresh_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == POS_FIRST) |-> (acc_r == '0) && !err_r && !fz_r)
    else $error("state not empty at literal start");

  a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    result.parse_error |-> (result.value == '0))
    else $error("nonzero value reported with an error");

endmodule

// ===== sv/ilp_out_reg.sv =====
// Result register of the integer literal parser.
// Holds one finished result request until the receiver takes it; uses ilp_pkg.
module ilp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ilp_pkg::ilp_out_t load_item,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output ilp_pkg::ilp_out_t out_item
);
  import ilp_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  ilp_out_t item_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ===== sv/int_literal_parser_top.sv =====
// Top level of the integer literal parser: input register, parse stage and
// result register. Depends on ilp_pkg, ilp_in_reg, ilp_accum and ilp_out_reg.
//
// Usage: characters of one integer literal arrive on the input channel
// (in_valid / in_ready / in_item), one request per character, with is_last
// set on the final one. A literal starting with "0x" or "0X" and followed by
// more characters is hexadecimal; anything else is decimal. After the last
// character one result request leaves on the output channel (out_valid /
// out_ready / out_item) with the value, or zero and parse_error set on a bad
// digit, a bare prefix, or a value above the largest signed 64-bit number.
//
// Throughput is one character per cycle unless a last character waits for
// the result slot: the parse stage is one pass of digit decode, a
// shift-and-add by ten or sixteen and a limit compare. The result of a last
// character passes through the input and result registers to out_valid.
//
// When the receiver stalls, characters that are not last keep flowing; a
// last character waits in the input register until the result slot frees.
// Synchronous active-low reset empties both registers and clears the parse
// state, so the next character starts a new literal.
module int_literal_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ilp_pkg::ilp_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output ilp_pkg::ilp_out_t out_item
);
  import ilp_pkg::*;

  logic     held_valid;
  ilp_in_t  held_item;
  logic     slot_free;
  logic     step;
  ilp_out_t result;

  // A character is processed whenever one is held, except that a last
  // character must also find room in the result register.
  assign step = held_valid && (!held_item.is_last || slot_free);

  ilp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_ready   (in_ready),
    .consume    (step),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ilp_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (held_item),
    .result (result)
  );

  ilp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && held_item.is_last),
    .load_item (result),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
